// ----- hdl/tpd_pkg.sv -----
// shared constants, tables and helpers of the three-point phase demodulator
package tpd_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 32;
    localparam int PRESCALE       = 30;
    localparam int CW             = 44;   // cordic x/y width
    localparam int SQRT_STEPS     = 26;   // result bits of the root
    localparam int ROOT_W         = 26;
    localparam int REM_W          = 29;
    localparam int SQ_W           = 20;
    localparam int OFF_W          = 10;
    localparam int AMP_FRAC       = 16;
    localparam int LANE_LAT       = CORDIC_STEPS + 3;
    localparam int IR_LAT         = 4;
    localparam int IR_W           = 17;
    localparam logic [IR_W-1:0] IR_MAX = 17'h1FFFF;
    // reciprocal of three, valid for dividends below 2^21
    localparam logic [19:0] RECIP3 = 20'hAAAAB;
    localparam int RECIP3_SH = 21;

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // raw byte to sample: 64 and above folds to 64 minus the byte
    function automatic logic signed [8:0] to_sample(input logic [7:0] b);
        logic signed [8:0] w;
        w = $signed({1'b0, b});
        return (b >= 8'd64) ? (9'sd64 - w) : w;
    endfunction

endpackage

// ----- hdl/tpd_lane.sv -----
// one frequency lane: sample fold, cordic vectoring and pipelined square root
module tpd_lane import tpd_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [7:0]              i_raw0,
    input  logic [7:0]              i_raw1,
    input  logic [7:0]              i_raw2,
    output logic [15:0]             o_phase,
    output logic [ROOT_W-1:0]       o_amp,
    output logic signed [OFF_W-1:0] o_off
);

    localparam logic [31:0] RND = 32'(1) << (31 - PHASE_BITS);

    logic signed [9:0]       r1_u, r1_v, n1_u, n1_v;
    logic signed [OFF_W-1:0] r1_off, n1_off;
    logic                    r1_zero, n1_zero;

    logic signed [CW-1:0]    r_x [0:CORDIC_STEPS];
    logic signed [CW-1:0]    r_y [0:CORDIC_STEPS];
    logic [31:0]             r_z [0:CORDIC_STEPS];
    logic                    r_zero [0:CORDIC_STEPS];
    logic signed [OFF_W-1:0] r_off [0:CORDIC_STEPS];
    logic [ROOT_W-1:0]       r_root [0:CORDIC_STEPS];
    logic [REM_W-1:0]        r_rem [0:SQRT_STEPS-1];
    logic [SQ_W-1:0]         r_sq [0:SQRT_STEPS-1];

    logic signed [CW-1:0]    n_x0, n_y0, xv, yv;
    logic [31:0]             n_z0;
    logic signed [19:0]      uu, vv;
    logic [SQ_W-1:0]         n_sq0;
    logic [31:0]             n_rz, n_sh;

    // sample fold and doubled deviations
    always_comb begin
        logic signed [8:0] s0, s1, s2;
        s0 = to_sample(i_raw0);
        s1 = to_sample(i_raw1);
        s2 = to_sample(i_raw2);
        n1_u    = 10'(s0) - 10'(s2);
        n1_v    = (10'(s1) <<< 1) - 10'(s0) - 10'(s2);
        n1_off  = OFF_W'(s0) + OFF_W'(s2);
        n1_zero = (n1_u == 10'sd0) && (n1_v == 10'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u    <= n1_u;
            r1_v    <= n1_v;
            r1_off  <= n1_off;
            r1_zero <= n1_zero;
        end
    end

    // squared magnitude and cordic start vector, folded to the right half plane
    always_comb begin
        uu = 20'(r1_u) * 20'(r1_u);
        vv = 20'(r1_v) * 20'(r1_v);
        n_sq0 = SQ_W'(uu) + SQ_W'(vv);
        xv = CW'(r1_v) <<< PRESCALE;
        yv = CW'(r1_u) <<< PRESCALE;
        if (r1_v < 0) begin
            n_x0 = -xv;
            n_y0 = -yv;
            n_z0 = 32'h80000000;
        end else begin
            n_x0 = xv;
            n_y0 = yv;
            n_z0 = 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= r1_zero;
            r_off[0]  <= r1_off;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_sq[0]   <= n_sq0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CW-1:0] n_x, n_y, dx, dy;
        logic [31:0]          n_z;
        logic [ROOT_W-1:0]    n_root;

        always_comb begin
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            if (!r_y[k][CW-1]) begin
                n_x = r_x[k] + dx;
                n_y = r_y[k] - dy;
                n_z = r_z[k] + ATAN_TAB[k];
            end else begin
                n_x = r_x[k] - dx;
                n_y = r_y[k] + dy;
                n_z = r_z[k] - ATAN_TAB[k];
            end
        end

        if (k < SQRT_STEPS) begin : g_sqrt
            logic [51:0]      num;
            logic [REM_W-1:0] tmp, trial, n_rem;

            always_comb begin
                num   = {32'(r_sq[k]), 20'h0} << 12;
                tmp   = {r_rem[k][REM_W-3:0], num[51-2*k -: 2]};
                trial = REM_W'({r_root[k], 2'b01});
                if (tmp >= trial) begin
                    n_rem  = tmp - trial;
                    n_root = {r_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = tmp;
                    n_root = {r_root[k][ROOT_W-2:0], 1'b0};
                end
            end

            if (k + 1 < SQRT_STEPS) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k+1] <= n_rem;
                        r_sq[k+1]  <= r_sq[k];
                    end
                end
            end
        end else begin : g_hold
            assign n_root = r_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_z[k+1]    <= n_z;
                r_zero[k+1] <= r_zero[k];
                r_off[k+1]  <= r_off[k];
                r_root[k+1] <= n_root;
            end
        end
    end

    // round the turn accumulator to the phase width, zero vector gives zero
    always_comb begin
        n_rz = r_z[CORDIC_STEPS] + RND;
        n_sh = n_rz >> (32 - PHASE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_phase <= r_zero[CORDIC_STEPS] ? 16'h0 : n_sh[15:0];
            o_amp   <= r_root[CORDIC_STEPS];
            o_off   <= r_off[CORDIC_STEPS];
        end
    end

    logic unused_xy;
    assign unused_xy = ^{r_x[CORDIC_STEPS], r_y[CORDIC_STEPS]};

endmodule

// ----- hdl/tpd_ir.sv -----
// ir level back end: offset minus amplitude, absolute value, divide by three
module tpd_ir import tpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [ROOT_W-1:0]       i_amp_a,
    input  logic [ROOT_W-1:0]       i_amp_b,
    input  logic [ROOT_W-1:0]       i_amp_c,
    input  logic signed [OFF_W-1:0] i_off_a,
    input  logic signed [OFF_W-1:0] i_off_b,
    input  logic signed [OFF_W-1:0] i_off_c,
    output logic [IR_W-1:0]         o_ir
);

    logic [27:0]        r_amp_sum;
    logic signed [11:0] r_off_sum;
    logic [20:0]        r_q, n_q;
    logic [40:0]        r_prod;
    logic signed [29:0] diff;
    logic [28:0]        mag;
    logic [36:0]        num;
    logic [19:0]        quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amp_sum <= 28'(i_amp_a) + 28'(i_amp_b) + 28'(i_amp_c);
            r_off_sum <= 12'(i_off_a) + 12'(i_off_b) + 12'(i_off_c);
        end
    end

    always_comb begin
        diff = (30'(r_off_sum) <<< AMP_FRAC) - $signed({2'b00, r_amp_sum});
        mag  = diff[29] ? 29'(-diff) : 29'(diff);
        num  = (37'(mag) << 7) + 37'(3 << (AMP_FRAC - 1));
        n_q  = num[36:AMP_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_prod <= 41'(r_q) * 41'(RECIP3);
        end
    end

    assign quo = r_prod[RECIP3_SH +: 20];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ir <= (quo > 20'(IR_MAX)) ? IR_MAX : quo[IR_W-1:0];
        end
    end

endmodule

// ----- hdl/tof_three_point_phase_demod.sv -----
// top level of the three-point time-of-flight phase demodulator
//
// one pixel enters as nine raw bytes, three samples for each of three
// modulation frequencies, and leaves as three phases and an ir level
// both channels use valid/stall; a transfer happens on a clock edge with
// valid high and stall low
// an input transfer reaches output valid through two front stages,
// 32 cordic micro-rotation stages (the root runs alongside in the
// first 26 of them), one rounding stage and four ir stages
// throughput is one pixel per cycle while the pipeline is not held
// the whole pipeline moves on one enable; it holds only while the output
// register has a result and the receiver stalls, and o_stall then
// follows so the sender holds its transfer
// reset is synchronous, active low, and clears the valid bits only
// phase is a fraction of a turn at PHASE_BITS bits, low 16 bits shown;
// ir level is q10.7 and saturates at its maximum
module tof_three_point_phase_demod import tpd_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_raw_s0,
    input  logic [7:0]  i_raw_s1,
    input  logic [7:0]  i_raw_s2,
    input  logic [7:0]  i_raw_s3,
    input  logic [7:0]  i_raw_s4,
    input  logic [7:0]  i_raw_s5,
    input  logic [7:0]  i_raw_s6,
    input  logic [7:0]  i_raw_s7,
    input  logic [7:0]  i_raw_s8,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_phase_a,
    output logic [15:0] o_phase_b,
    output logic [15:0] o_phase_c,
    output logic [16:0] o_ir_level
);

    localparam int LAT = LANE_LAT + IR_LAT;

    logic en;
    logic r_vld [0:LAT-1];

    logic [15:0]             ph_a, ph_b, ph_c;
    logic [ROOT_W-1:0]       amp_a, amp_b, amp_c;
    logic signed [OFF_W-1:0] off_a, off_b, off_c;
    logic [15:0]             r_pa [0:IR_LAT-1];
    logic [15:0]             r_pb [0:IR_LAT-1];
    logic [15:0]             r_pc [0:IR_LAT-1];

    // advance unless a finished result is held by the receiver
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    tpd_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_a (
        .i_clk(i_clk), .i_en(en),
        .i_raw0(i_raw_s0), .i_raw1(i_raw_s1), .i_raw2(i_raw_s2),
        .o_phase(ph_a), .o_amp(amp_a), .o_off(off_a)
    );

    tpd_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_b (
        .i_clk(i_clk), .i_en(en),
        .i_raw0(i_raw_s3), .i_raw1(i_raw_s4), .i_raw2(i_raw_s5),
        .o_phase(ph_b), .o_amp(amp_b), .o_off(off_b)
    );

    tpd_lane #(.PHASE_BITS(PHASE_BITS)) u_lane_c (
        .i_clk(i_clk), .i_en(en),
        .i_raw0(i_raw_s6), .i_raw1(i_raw_s7), .i_raw2(i_raw_s8),
        .o_phase(ph_c), .o_amp(amp_c), .o_off(off_c)
    );

    tpd_ir u_ir (
        .i_clk(i_clk), .i_en(en),
        .i_amp_a(amp_a), .i_amp_b(amp_b), .i_amp_c(amp_c),
        .i_off_a(off_a), .i_off_b(off_b), .i_off_c(off_c),
        .o_ir(o_ir_level)
    );

    // phases wait for the ir back end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa[0] <= ph_a;
            r_pb[0] <= ph_b;
            r_pc[0] <= ph_c;
            for (int k = 1; k < IR_LAT; k++) begin
                r_pa[k] <= r_pa[k-1];
                r_pb[k] <= r_pb[k-1];
                r_pc[k] <= r_pc[k-1];
            end
        end
    end

    assign o_phase_a = r_pa[IR_LAT-1];
    assign o_phase_b = r_pb[IR_LAT-1];
    assign o_phase_c = r_pc[IR_LAT-1];

endmodule

// ----- hdl/tpd_checker.sv -----
// port-level checks of the demodulator, bound to the top level
module tpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_phase_a,
    input logic [16:0] o_ir_level
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a held result holds the input side too
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while result held");

    // no result waiting means no backpressure
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall without pending result");

    // held result stays valid and keeps its phase a and ir level
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_phase_a) && $stable(o_ir_level)))
        else $error("held result changed");

endmodule

bind tof_three_point_phase_demod tpd_checker u_tpd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_phase_a(o_phase_a),
    .o_ir_level(o_ir_level)
);

// ----- tb/sv/tof_three_point_phase_demod_tb.sv -----
// testbench of the three-point time-of-flight phase demodulator
`timescale 1ns / 1ps

module tof_three_point_phase_demod_tb import tpd_pkg::*; ();

    localparam int PB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] phase_a;
        logic [15:0] phase_b;
        logic [15:0] phase_c;
        logic [16:0] ir_level;
    } t_pixel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  raw [0:8];
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_phase_a, o_phase_b, o_phase_c;
    logic [16:0] o_ir_level;

    t_pixel_out pixel_q [$];
    int  mismatches;
    int  idle_cycles;
    bit  timed_out;
    bit  rx_hold;      // long receiver hold-off
    bit  rx_quiet;     // receiver never stalls

    tof_three_point_phase_demod dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_raw_s0(raw[0]), .i_raw_s1(raw[1]), .i_raw_s2(raw[2]),
        .i_raw_s3(raw[3]), .i_raw_s4(raw[4]), .i_raw_s5(raw[5]),
        .i_raw_s6(raw[6]), .i_raw_s7(raw[7]), .i_raw_s8(raw[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_phase_a(o_phase_a), .o_phase_b(o_phase_b), .o_phase_c(o_phase_c),
        .o_ir_level(o_ir_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fold_byte(input logic [7:0] b);
        return (b >= 8'd64) ? 64 - int'(b) : int'(b);
    endfunction

    function automatic longint floor_shift(input longint a, input int s);
        if (a >= 0) return a >>> s;
        return -((-a - 1) >>> s) - 1;
    endfunction

    // cordic vectoring in turns, rounded to PB bits
    function automatic logic [15:0] triplet_phase(input int u, input int v);
        longint x, y, dx, dy;
        logic [31:0] z;
        logic [31:0] r;
        if (u == 0 && v == 0) return 16'd0;
        x = longint'(v) <<< PRESCALE;
        y = longint'(u) <<< PRESCALE;
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        r = (z + (32'd1 << (31 - PB))) >> (32 - PB);
        return r[15:0];
    endfunction

    function automatic longint unsigned root_u64(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_pixel_out demod_pixel(input logic [7:0] b [0:8]);
        t_pixel_out p;
        longint off_sum, amp_sum, diff;
        longint unsigned mag, ir;
        int s0, s1, s2, u, v;
        logic [15:0] ph [0:2];
        off_sum = 0;
        amp_sum = 0;
        for (int t = 0; t < 3; t++) begin
            s0 = fold_byte(b[3*t]);
            s1 = fold_byte(b[3*t+1]);
            s2 = fold_byte(b[3*t+2]);
            u = s0 - s2;
            v = 2 * s1 - s0 - s2;
            ph[t] = triplet_phase(u, v);
            off_sum += s0 + s2;
            amp_sum += longint'(root_u64(longint'(u*u + v*v) << (2*AMP_FRAC)));
        end
        diff = (off_sum <<< AMP_FRAC) - amp_sum;
        mag = (diff < 0) ? -diff : diff;
        ir = (mag * 128 + 3 * (64'd1 << (AMP_FRAC - 1))) / (3 * (64'd1 << AMP_FRAC));
        if (ir > 131071) ir = 131071;
        p.phase_a = ph[0];
        p.phase_b = ph[1];
        p.phase_c = ph[2];
        p.ir_level = ir[16:0];
        return p;
    endfunction

    function automatic int short_or_long_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one pixel transfer; holds valid and data until accepted, valid stays
    // high afterwards so the next transfer can follow with no gap
    task automatic send_pixel(input logic [7:0] b [0:8], input bit with_gaps);
        int gap;
        gap = with_gaps ? short_or_long_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 9; k++) raw[k] <= b[k];
        do @(posedge i_clk); while (o_stall);
        pixel_q = {pixel_q, demod_pixel(b)};
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    task automatic send_bytes9(input logic [71:0] v, input bit g);
        logic [7:0] b [0:8];
        for (int k = 0; k < 9; k++) b[k] = v[8*k +: 8];
        send_pixel(b, g);
    endtask

    // extremes of the fold, zero vector, half turn on zero sine, axes
    task automatic test_directed();
        logic [7:0] b [0:8];
        send_bytes9({9{8'h00}}, 0);
        send_bytes9({9{8'hFF}}, 0);
        send_bytes9({9{8'h3F}}, 0);
        send_bytes9({9{8'h40}}, 0);
        send_bytes9({9{8'h41}}, 0);
        send_bytes9({9{8'hAA}}, 0);
        send_bytes9({9{8'h55}}, 0);
        for (int t = 0; t < 3; t++) begin
            // zero sine, negative cosine: s0 = s2, s1 below them
            b = '{default: 8'd0};
            b[3*t] = 8'd20; b[3*t+1] = 8'd0; b[3*t+2] = 8'd20;
            send_pixel(b, 0);
            // zero sine, positive cosine
            b = '{default: 8'd0};
            b[3*t+1] = 8'd63;
            send_pixel(b, 0);
            // nearly pure positive sine, then negative sine equal to the cosine
            b = '{default: 8'd0};
            b[3*t] = 8'd63; b[3*t+1] = 8'd31; b[3*t+2] = 8'd0;
            send_pixel(b, 0);
            b = '{default: 8'd0};
            b[3*t] = 8'hFF; b[3*t+1] = 8'd63; b[3*t+2] = 8'd63;
            send_pixel(b, 0);
        end
        send_bytes9(72'h00FF3F_00FF3F_00FF3F, 0);
        send_bytes9(72'hFF003F_FF003F_FF003F, 0);
        send_bytes9(72'h3F00FF_FF3F00_00FF3F, 0);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        logic [7:0] b [0:8];
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 9; k++) begin
                case ($urandom_range(0, 5))
                    0: b[k] = 8'($urandom_range(0, 63));
                    1: b[k] = 8'($urandom_range(64, 80));
                    2: b[k] = 8'($urandom_range(240, 255));
                    default: b[k] = 8'($urandom());
                endcase
            end
            send_pixel(b, 1);
        end
    endtask

    // receiver holds off long enough that the pipeline fills and backs up
    task automatic test_backpressure();
        logic [7:0] b [0:8];
        rx_hold = 1'b1;
        fork
            begin
                repeat (150) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 80; i++) begin
                    for (int k = 0; k < 9; k++) b[k] = 8'($urandom());
                    send_pixel(b, 0);
                end
            end
        join
        wait_drained();
    endtask

    task automatic test_streaming();
        rx_quiet = 1'b1;
        test_random(100);
        wait_drained();
        rx_quiet = 1'b0;
    endtask

    // receiver stall: random gaps, forced on by the hold-off and off when quiet
    initial begin
        int g;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                g = short_or_long_gap();
                if (g == 0) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= 1'b1;
                    repeat (g - 1) begin
                        @(posedge i_clk);
                        if (rx_quiet) break;
                    end
                end
            end
        end
    end

    // result checker against oldest expectation
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h %h",
                             o_phase_a, o_phase_b, o_phase_c, o_ir_level);
            end else begin
                want = pixel_q.pop_front();
                if (want.phase_a !== o_phase_a || want.phase_b !== o_phase_b ||
                    want.phase_c !== o_phase_c || want.ir_level !== o_ir_level) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h got %h %h %h %h",
                                 want.phase_a, want.phase_b, want.phase_c,
                                 want.ir_level, o_phase_a, o_phase_b,
                                 o_phase_c, o_ir_level);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        rx_hold = 1'b0;
        rx_quiet = 1'b0;
        i_valid <= 1'b0;
        for (int k = 0; k < 9; k++) raw[k] <= 8'd0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_streaming();
        test_random(500);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tpd_pkg.sv
hdl/tpd_lane.sv
hdl/tpd_ir.sv
hdl/tof_three_point_phase_demod.sv
hdl/tpd_checker.sv
tb/sv/tof_three_point_phase_demod_tb.sv
